// ----- src/billboard_sprite_projection_assert.svh -----
// Assertion macros for the checker file of the sprite projection block
`ifndef BILLBOARD_SPRITE_PROJECTION_ASSERT_SVH
`define BILLBOARD_SPRITE_PROJECTION_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprite projection check failed");

// Check that the consequent holds in the cycle after the antecedent
`define BSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite projection check failed");

`endif

// ----- src/bsp_pkg.sv -----
// Types, constants and helpers of the sprite projection block
`timescale 1ns / 1ps
package bsp_pkg;

	// Divider operand widths: numerator magnitude, divisor magnitude, signed quotient
	localparam int NUM_W  = 62;
	localparam int DEN_W  = 48;
	localparam int QUO_W  = 64;
	localparam int STEP_W = $clog2(NUM_W);

	// Job queue depth between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// Register indexes of the configuration port
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	localparam logic [15:0] SIZE_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0]        object_x;
		logic [15:0]        object_y;
		logic [15:0]        viewer_x;
		logic [15:0]        viewer_y;
		logic signed [15:0] facing_x;
		logic signed [15:0] facing_y;
		logic signed [15:0] lens_x;
		logic signed [15:0] lens_y;
		logic               final_sprite;
	} bsp_in_t;

	typedef struct packed {
		logic               visible;
		logic signed [15:0] depth;
		logic signed [15:0] centre_column;
		logic [15:0]        span_size;
		logic [14:0]        first_column;
		logic signed [15:0] end_column;
		logic [11:0]        first_row;
		logic [11:0]        end_row;
		logic               final_out;
	} bsp_out_t;

	// Classified sprite handed from front to back: numerator and divisor magnitudes
	typedef struct packed {
		logic [NUM_W-1:0] nx_mag;
		logic             nx_neg;
		logic [NUM_W-1:0] ny_mag;
		logic             ny_neg;
		logic [DEN_W-1:0] det_mag;
		logic             det_neg;
		logic             det_zero;
		logic             final_sprite;
	} bsp_job_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} bsp_qstat_t;

	// Saturate a 64-bit signed value into 16 signed bits
	function automatic logic signed [15:0] sat_s16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v < -64'sd32768)
			r = -16'sd32768;
		else if (v > 64'sd32767)
			r = 16'sd32767;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// ----- src/bsp_front.sv -----
// Front part: accept sprites, form camera-space numerators and determinant
`timescale 1ns / 1ps
module bsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsp_pkg::bsp_in_t  in_data,
	input  bsp_pkg::bsp_qstat_t qstat,
	output logic              push,
	output bsp_pkg::bsp_job_t push_job
);
	import bsp_pkg::*;

	logic               v_s1, v_s2;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [15:0] fx_s1, fy_s1, lx_s1, ly_s1;
	logic               fin_s1, fin_s2;
	logic signed [32:0] fydx_s2, fxdy_s2, lxdy_s2, lydx_s2;
	logic signed [31:0] lxfy_s2, fxly_s2;
	logic signed [33:0] nx, ny;
	logic signed [32:0] det;
	logic [33:0]        nx_abs, ny_abs;
	logic [32:0]        det_abs;
	logic [QCNT_W:0]    occupancy;
	logic               accept;

	// Reserve a queue slot for every sprite still in the front stages
	assign occupancy = (QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2);
	assign in_ready  = occupancy < (QCNT_W+1)'(QDEPTH);
	assign accept    = in_valid && in_ready;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: offsets from the viewer
	always_ff @(posedge clk) begin
		if (accept) begin
			dx_s1  <= $signed({1'b0, in_data.object_x}) - $signed({1'b0, in_data.viewer_x});
			dy_s1  <= $signed({1'b0, in_data.object_y}) - $signed({1'b0, in_data.viewer_y});
			fx_s1  <= in_data.facing_x;
			fy_s1  <= in_data.facing_y;
			lx_s1  <= in_data.lens_x;
			ly_s1  <= in_data.lens_y;
			fin_s1 <= in_data.final_sprite;
		end
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (v_s1) begin
			fydx_s2 <= fy_s1 * dx_s1;
			fxdy_s2 <= fx_s1 * dy_s1;
			lxdy_s2 <= lx_s1 * dy_s1;
			lydx_s2 <= ly_s1 * dx_s1;
			lxfy_s2 <= lx_s1 * fy_s1;
			fxly_s2 <= fx_s1 * ly_s1;
			fin_s2  <= fin_s1;
		end
	end

	// Differences, then split into sign and magnitude for the back
	assign nx      = fydx_s2 - fxdy_s2;
	assign ny      = lxdy_s2 - lydx_s2;
	assign det     = lxfy_s2 - fxly_s2;
	assign nx_abs  = nx[33] ? 34'(-nx) : 34'(nx);
	assign ny_abs  = ny[33] ? 34'(-ny) : 34'(ny);
	assign det_abs = det[32] ? 33'(-det) : 33'(det);

	assign push = v_s2;
	always_comb begin
		push_job.nx_mag       = NUM_W'({nx_abs, 14'b0});
		push_job.nx_neg       = nx[33];
		push_job.ny_mag       = NUM_W'({ny_abs, 14'b0});
		push_job.ny_neg       = ny[33];
		push_job.det_mag      = DEN_W'(det_abs);
		push_job.det_neg      = det[32];
		push_job.det_zero     = (det == 33'sd0);
		push_job.final_sprite = fin_s2;
	end

endmodule

// ----- src/bsp_queue.sv -----
// Short job queue between the front and the back
`timescale 1ns / 1ps
module bsp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bsp_pkg::bsp_job_t   push_job,
	input  logic                pop,
	output bsp_pkg::bsp_job_t   head,
	output bsp_pkg::bsp_qstat_t qstat
);
	import bsp_pkg::*;

	bsp_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head        = mem_q[rd_q];
	assign qstat.count = cnt_q;
	assign qstat.empty = (cnt_q == '0);

endmodule

// ----- src/bsp_div.sv -----
// Bit-serial restoring divider with sign applied to the quotient
`timescale 1ns / 1ps
module bsp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [bsp_pkg::NUM_W-1:0]        num,
	input  logic [bsp_pkg::DEN_W-1:0]        den,
	input  logic                             neg,
	output logic                             done,
	output logic signed [bsp_pkg::QUO_W-1:0] quo
);
	import bsp_pkg::*;

	logic              busy_q, done_q, neg_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    rem_q, rem_sh, rem_nx;
	logic              ge;

	// One quotient bit per cycle
	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == STEP_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift numerator out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			neg_q <= neg;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(QUO_W'(num_q)) : $signed(QUO_W'(num_q));

endmodule

// ----- src/bsp_back.sv -----
// Back part: divisions, size and bounds, output register
`timescale 1ns / 1ps
module bsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [12:0]         screen_width,
	input  logic [12:0]         screen_height,
	input  bsp_pkg::bsp_job_t   head,
	input  bsp_pkg::bsp_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output bsp_pkg::bsp_out_t   out_data
);
	import bsp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV1   = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_LAUNCH = 6'b001000,
		ST_DIV2   = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t                   state_q;
	logic                     det_zero_q, fin_q, out_valid_q;
	logic signed [QUO_W-1:0]  tx_q, ty_q, col_q;
	logic signed [NUM_W:0]    cnum_q;
	logic [15:0]              size_q;
	bsp_out_t                 out_q, res;

	logic                     start_ab, done_a, done_b;
	logic [NUM_W-1:0]         num_a, num_b;
	logic [DEN_W-1:0]         den_ab;
	logic                     neg_a, neg_b;
	logic signed [QUO_W-1:0]  quo_a, quo_b;

	logic [11:0]              half_w, half_h;
	logic signed [QUO_W-1:0]  ty_abs;
	logic                     ty_zero;
	logic signed [48:0]       sum49;
	logic [NUM_W:0]           cnum_abs;
	logic                     out_free;

	assign half_w   = screen_width[12:1];
	assign half_h   = screen_height[12:1];
	assign ty_zero  = (ty_q == '0);
	assign ty_abs   = ty_q[QUO_W-1] ? -ty_q : ty_q;
	assign sum49    = 49'(ty_q + tx_q);
	assign cnum_abs = cnum_q[NUM_W] ? (NUM_W+1)'(-cnum_q) : (NUM_W+1)'(cnum_q);
	assign out_free = !out_valid_q || out_ready;

	assign pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign start_ab = pop || (state_q == ST_LAUNCH);

	// Select divider operands: camera transform first, then column and size
	always_comb begin
		if (state_q == ST_IDLE) begin
			num_a  = head.nx_mag;
			num_b  = head.ny_mag;
			den_ab = head.det_mag;
			neg_a  = head.nx_neg ^ head.det_neg;
			neg_b  = head.ny_neg ^ head.det_neg;
		end else begin
			num_a  = cnum_abs[NUM_W-1:0];
			num_b  = NUM_W'({screen_height, 8'b0});
			den_ab = ty_abs[DEN_W-1:0];
			neg_a  = cnum_q[NUM_W] ^ ty_q[QUO_W-1];
			neg_b  = 1'b0;
		end
	end

	bsp_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ab),
		.num    (num_a),
		.den    (den_ab),
		.neg    (neg_a),
		.done   (done_a),
		.quo    (quo_a)
	);

	bsp_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ab),
		.num    (num_b),
		.den    (den_ab),
		.neg    (neg_b),
		.done   (done_b),
		.quo    (quo_b)
	);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:   if (pop) state_q <= ST_DIV1;
				ST_DIV1:   if (done_a && done_b) state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_LAUNCH;
				ST_LAUNCH: state_q <= ST_DIV2;
				ST_DIV2:   if (done_a && done_b) state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture intermediate results
	always_ff @(posedge clk) begin
		if (pop) begin
			det_zero_q <= head.det_zero;
			fin_q      <= head.final_sprite;
		end
		if (state_q == ST_DIV1 && done_a) begin
			tx_q <= det_zero_q ? '0 : quo_a;
			ty_q <= det_zero_q ? '0 : quo_b;
		end
		if (state_q == ST_MUL)
			cnum_q <= $signed({1'b0, half_w}) * sum49;
		if (state_q == ST_DIV2 && done_a) begin
			col_q  <= ty_zero ? $signed(QUO_W'(half_w)) : quo_a;
			size_q <= (ty_zero || quo_b > $signed(QUO_W'(SIZE_MAX))) ? SIZE_MAX
			          : quo_b[15:0];
		end
		if (state_q == ST_FIN && out_free)
			out_q <= res;
	end

	// Clamp bounds
	always_comb begin
		logic signed [QUO_W-1:0] hs, hh, w, h, rs, re, cs, ce;
		hs = $signed(QUO_W'(size_q[15:1]));
		hh = $signed(QUO_W'(half_h));
		w  = $signed(QUO_W'(screen_width));
		h  = $signed(QUO_W'(screen_height));

		rs = hh - hs;
		if (rs < 0)
			rs = '0;
		re = hs + hh;
		if (re >= h)
			re = h - 1;
		if (re < 0)
			re = '0;
		else if (re > 4095)
			re = 4095;

		cs = col_q - hs;
		if (cs < 0)
			cs = '0;
		else if (cs > 32767)
			cs = 32767;
		ce = hs + col_q;
		if (ce >= w)
			ce = w - 1;

		res.visible       = !ty_q[QUO_W-1] && !ty_zero;
		res.depth         = sat_s16(ty_q);
		res.centre_column = sat_s16(col_q);
		res.span_size     = size_q;
		res.first_column  = cs[14:0];
		res.end_column    = sat_s16(ce);
		res.first_row     = rs[11:0];
		res.end_row       = re[11:0];
		res.final_out     = fin_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/billboard_sprite_projection.sv -----
// Top level of the billboard sprite projection block
`timescale 1ns / 1ps
// Projects one sprite per transaction into screen space: camera-space depth,
// centre column, square size and clamped draw bounds. The front accepts a
// sprite per cycle while the job queue has room (in_ready) into a two-stage
// multiply pipeline feeding a four-entry job queue, so an idle block takes up
// to five sprites back to back (four waiting, one in the back). The back runs
// two bit-serial 62-step dividers twice per sprite (transform, then column
// and size) and works on one sprite at a time; the queue takes new sprites
// meanwhile. Write screen_width and screen_height only while the block is
// idle.
module billboard_sprite_projection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsp_pkg::bsp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bsp_pkg::bsp_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data
);
	import bsp_pkg::*;

	logic [12:0] width_q, height_q;
	logic        push, pop;
	bsp_job_t    push_job, head;
	bsp_qstat_t  qstat;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default:           width_q  <= width_q;
			endcase
		end
	end

	bsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.qstat    (qstat),
		.push     (push),
		.push_job (push_job)
	);

	bsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	bsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.screen_width  (width_q),
		.screen_height (height_q),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

// ----- src/bsp_checker.sv -----
// Port-level checks of the sprite projection block and their binding
`timescale 1ns / 1ps
`include "billboard_sprite_projection_assert.svh"
module bsp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input bsp_pkg::bsp_out_t out_data
);
	import bsp_pkg::*;

	// Hold a stalled result transaction
	`BSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`BSP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

	// A visible sprite lies in front of the camera
	`BSP_ASSERT_NOW(a_visible_depth, out_valid && out_data.visible,
		!out_data.depth[15] && out_data.depth != 16'sd0)

	// Zero depth saturates the size
	`BSP_ASSERT_NOW(a_zero_depth_size, out_valid && out_data.depth == 16'sd0,
		out_data.span_size == SIZE_MAX && !out_data.visible)

endmodule

bind billboard_sprite_projection bsp_checker u_bsp_checker (.*);

// ----- bench/billboard_sprite_projection_tb.sv -----
// Testbench for the billboard sprite projection block: directed and random sprites checked against a predictor
`timescale 1ns / 1ps
module billboard_sprite_projection_tb;
	import bsp_pkg::*;

	// Predicts each sprite's projection and holds the projections still due
	class projection_scoreboard;
		longint     width;
		longint     height;
		bsp_out_t   due_q[$];
		int         accepted;
		int         failures;

		function void set_screen(longint w, longint h);
			width  = w;
			height = h;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function bsp_out_t project(bsp_in_t s);
			bsp_out_t r;
			longint dx, dy, fx, fy, lx, ly, hw, hh, det, nx, ny, tx, ty;
			longint col, size, hs, rs, re, cs, ce;
			dx = longint'(s.object_x) - longint'(s.viewer_x);
			dy = longint'(s.object_y) - longint'(s.viewer_y);
			fx = longint'(s.facing_x);
			fy = longint'(s.facing_y);
			lx = longint'(s.lens_x);
			ly = longint'(s.lens_y);
			hw = width / 2;
			hh = height / 2;
			// Inverse camera transform; a singular camera gives the origin
			det = lx * fy - fx * ly;
			tx = 0;
			ty = 0;
			if (det != 0) begin
				nx = fy * dx - fx * dy;
				ny = lx * dy - ly * dx;
				tx = (nx * 16384) / det;
				ty = (ny * 16384) / det;
			end
			// Zero depth saturates the size and centers the sprite
			if (ty == 0) begin
				col  = hw;
				size = 65535;
			end else begin
				col  = (hw * (ty + tx)) / ty;
				size = (height * 256) / ty;
				if (size < 0)
					size = -size;
				if (size > 65535)
					size = 65535;
			end
			hs = size / 2;
			rs = hh - hs;
			if (rs < 0)
				rs = 0;
			re = hs + hh;
			if (re >= height)
				re = height - 1;
			cs = col - hs;
			if (cs < 0)
				cs = 0;
			ce = hs + col;
			if (ce >= width)
				ce = width - 1;
			r.visible       = (ty > 0);
			r.depth         = 16'(clamp(ty, -32768, 32767));
			r.centre_column = 16'(clamp(col, -32768, 32767));
			r.span_size     = 16'(size);
			r.first_column  = 15'(clamp(cs, 0, 32767));
			r.end_column    = 16'(clamp(ce, -32768, 32767));
			r.first_row     = 12'(clamp(rs, 0, 4095));
			r.end_row       = 12'(clamp(re, 0, 4095));
			r.final_out     = s.final_sprite;
			return r;
		endfunction

		function void note_sprite(bsp_in_t s);
			due_q.push_back(project(s));
			accepted++;
		endfunction

		function void check_projection(bsp_out_t a);
			bsp_out_t e;
			if (due_q.size() == 0) begin
				$error("projection with none due: %p", a);
				failures++;
				return;
			end
			e = due_q.pop_front();
			if (a.visible !== e.visible) begin
				$error("visible: expected %0d, got %0d", e.visible, a.visible);
				failures++;
			end
			if (a.depth !== e.depth) begin
				$error("depth: expected %0d, got %0d", e.depth, a.depth);
				failures++;
			end
			if (a.centre_column !== e.centre_column) begin
				$error("centre_column: expected %0d, got %0d", e.centre_column,
					a.centre_column);
				failures++;
			end
			if (a.span_size !== e.span_size) begin
				$error("span_size: expected %0d, got %0d", e.span_size, a.span_size);
				failures++;
			end
			if (a.first_column !== e.first_column) begin
				$error("first_column: expected %0d, got %0d", e.first_column,
					a.first_column);
				failures++;
			end
			if (a.end_column !== e.end_column) begin
				$error("end_column: expected %0d, got %0d", e.end_column, a.end_column);
				failures++;
			end
			if (a.first_row !== e.first_row) begin
				$error("first_row: expected %0d, got %0d", e.first_row, a.first_row);
				failures++;
			end
			if (a.end_row !== e.end_row) begin
				$error("end_row: expected %0d, got %0d", e.end_row, a.end_row);
				failures++;
			end
			if (a.final_out !== e.final_out) begin
				$error("final_out: expected %0d, got %0d", e.final_out, a.final_out);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	bsp_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	bsp_out_t    out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_SCREEN_WIDTH;
	logic [12:0] cfg_data = '0;

	projection_scoreboard sb = new();
	bit          held_off = 1'b0;

	billboard_sprite_projection i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Generate the 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	// Check every accepted projection
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_projection(out_data);
	end

	// Stall the output on a pattern of its own, with one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(negedge clk);
				if (!held_off && sb.accepted >= 300) begin
					held_off = 1'b1;
					out_ready <= 1'b0;
					repeat (3000) @(negedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// Offer one transaction and hold it until accepted; returns at a falling edge
	task automatic send_sprite(bsp_in_t s);
		in_valid <= 1'b1;
		in_data  <= s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_sprite(s);
		@(negedge clk);
	endtask

	// Drop valid for a random gap, or keep streaming
	task automatic pause_sender();
		int gap;
		gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 30);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Write both screen registers while the block is idle
	task automatic set_screen(logic [12:0] w, logic [12:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_screen(w, h);
	endtask

	// Drain all projections, then let the back end settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_q.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic bsp_in_t random_sprite();
		bsp_in_t      s;
		logic [159:0] raw;
		int           k;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		s = raw[$bits(bsp_in_t)-1:0];
		s.final_sprite = ($urandom_range(0, 7) == 0);
		// Most sprites use an orthogonal camera near the viewer
		if ($urandom_range(0, 9) < 7) begin
			s.facing_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
			s.facing_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
			k = $urandom_range(1, 4);
			s.lens_x   = 16'(-(s.facing_y * k) / 4);
			s.lens_y   = 16'((s.facing_x * k) / 4);
			s.object_x = s.viewer_x + 16'($urandom_range(0, 8192)) - 16'd4096;
			s.object_y = s.viewer_y + 16'($urandom_range(0, 8192)) - 16'd4096;
			if ($urandom_range(0, 19) == 0)
				s.object_x = s.viewer_x;
		end
		return s;
	endfunction

	// Stimulus
	initial begin
		bsp_in_t      s;
		bsp_in_t      dir_q[$];
		logic [12:0]  widths[7]  = '{640, 1, 4096, 8191, 0, 320, 8191};
		logic [12:0]  heights[7] = '{480, 1, 4096, 8191, 0, 200, 1};
		sb.set_screen(WIDTH_RESET, HEIGHT_RESET);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sprites: extremes, singular camera, behind and ahead
		s = '0;
		dir_q.push_back(s);
		s = '1;
		dir_q.push_back(s);
		s = '0;
		s.facing_x = 16'sd16384;
		s.lens_y   = -16'sd10813;
		s.object_x = 16'd2560;
		s.viewer_x = 16'd512;
		dir_q.push_back(s);
		s.object_x = 16'd256;
		dir_q.push_back(s);
		s.object_x = 16'd513;
		s.object_y = 16'd700;
		s.final_sprite = 1'b1;
		dir_q.push_back(s);
		s = '0;
		s.object_x = 16'hFFFF;
		s.object_y = 16'hFFFF;
		s.facing_x = 16'sd1;
		s.lens_y   = -16'sd1;
		dir_q.push_back(s);
		s.facing_x = -16'sd32768;
		s.lens_y   = 16'sd32767;
		s.viewer_x = 16'hFFFF;
		s.object_x = 16'h0000;
		dir_q.push_back(s);
		s = '0;
		s.facing_x = 16'sd16384;
		s.lens_x   = 16'sd16384;
		s.object_x = 16'd1000;
		dir_q.push_back(s);
		s = '0;
		s.facing_y = 16'sd1;
		s.lens_x   = 16'sd1;
		s.object_y = 16'd1;
		dir_q.push_back(s);
		s.facing_y = 16'sd32767;
		s.lens_x   = -16'sd32768;
		s.object_x = 16'hFFFF;
		s.viewer_y = 16'hFFFF;
		dir_q.push_back(s);
		foreach (dir_q[i]) begin
			send_sprite(dir_q[i]);
			pause_sender();
		end
		drain();

		// Random phases, one screen setting each
		foreach (widths[p]) begin
			set_screen(widths[p], heights[p]);
			repeat ((p == 0) ? 400 : 140) begin
				send_sprite(random_sprite());
				if ($urandom_range(0, 5) == 0)
					pause_sender();
			end
			drain();
		end

		if (sb.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
